// ----- design/text_line_reveal_strips_assert.svh -----
// assertion helpers for the text reveal block
`ifndef TEXT_LINE_REVEAL_STRIPS_ASSERT_SVH
`define TEXT_LINE_REVEAL_STRIPS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TLRS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tlrs check failed");

// next-cycle implication, checked outside reset
`define TLRS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tlrs check failed");

`endif

// ----- design/tlrs_pkg.sv -----
package tlrs_pkg;

   localparam int MAX_LINES       = 16;
   localparam int MAX_SOFT_SLICES = 16;
   localparam int ADDR_W          = $clog2(MAX_LINES);
   localparam int CNT_W           = $clog2(MAX_LINES + 1);

   // shared divider sizes
   localparam int DIV_W     = 30;
   localparam int DVR_W     = 13;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // register indexes
   localparam logic [2:0] REG_TEXT_X      = 3'd0;
   localparam logic [2:0] REG_TEXT_Y      = 3'd1;
   localparam logic [2:0] REG_TEX_WIDTH   = 3'd2;
   localparam logic [2:0] REG_TEX_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_REVEAL_FRAC = 3'd4;
   localparam logic [2:0] REG_SOFT_WIDTH  = 3'd5;
   localparam logic [2:0] REG_SOFT_STEPS  = 3'd6;
   localparam logic [2:0] REG_TINT_ALPHA  = 3'd7;

   localparam logic [16:0] FRAC_ONE = 17'd65536;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- design/tlrs_div.sv -----
module tlrs_div
   import tlrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DVR_W-1:0]     rem_ff;
   logic [DVR_W-1:0]     dvr_ff;
   logic [DVR_W:0]       trial;
   logic [DVR_W:0]       diff;
   logic                 ge;

   // one restoring step per cycle
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvr_ff};
   assign ge    = (trial >= {1'b0, dvr_ff});

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dvr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- design/text_line_reveal_strips.sv -----
// Line rectangles of one text come in one item per cycle and are kept (up to
// MAX_LINES, later ones are dropped) while their widths are summed. The item
// with tlast set starts the reveal walk and the block takes no item until the
// walk is done; strips then leave on the rsp_ side, the final one with tlast.
// Every strip needs up to four texture-coordinate divisions and each soft slice
// up to two more, all on one shared 30-step divider.
module text_line_reveal_strips
   import tlrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata: line_x, line_y, line_w, line_h, zero fill
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic         req_tlast,
   // rsp_tdata: strip_x, strip_y, strip_w, strip_h, tex_u0, tex_v0, tex_u1,
   // tex_v1, strip_alpha, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

`include "text_line_reveal_strips_assert.svh"

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_REVEAL = 12'b000000000010,
      ST_RD     = 12'b000000000100,
      ST_LINE   = 12'b000000001000,
      ST_TEX    = 12'b000000010000,
      ST_TEXW   = 12'b000000100000,
      ST_PUSH   = 12'b000001000000,
      ST_SLB    = 12'b000010000000,
      ST_SLBW   = 12'b000100000000,
      ST_SLAL   = 12'b001000000000,
      ST_SLALW  = 12'b010000000000,
      ST_FIN    = 12'b100000000000
   } state_type;

   state_type state_ff;

   // configuration
   logic signed [19:0] text_x_ff, text_y_ff;
   logic [12:0] tex_width_ff, tex_height_ff;
   logic [16:0] reveal_frac_ff;
   logic [15:0] soft_width_ff;
   logic [4:0]  soft_steps_ff;
   logic [7:0]  tint_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_x_ff      <= '0;
         text_y_ff      <= '0;
         tex_width_ff   <= 13'd1;
         tex_height_ff  <= 13'd1;
         reveal_frac_ff <= FRAC_ONE;
         soft_width_ff  <= '0;
         soft_steps_ff  <= '0;
         tint_alpha_ff  <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            REG_TEXT_X:      text_x_ff      <= csr_wdata;
            REG_TEXT_Y:      text_y_ff      <= csr_wdata;
            REG_TEX_WIDTH:   tex_width_ff   <= csr_wdata[12:0];
            REG_TEX_HEIGHT:  tex_height_ff  <= csr_wdata[12:0];
            REG_REVEAL_FRAC: reveal_frac_ff <= csr_wdata[16:0];
            REG_SOFT_WIDTH:  soft_width_ff  <= csr_wdata[15:0];
            REG_SOFT_STEPS:  soft_steps_ff  <= csr_wdata[4:0];
            REG_TINT_ALPHA:  tint_alpha_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // line store
   logic [67:0]       store_mem [MAX_LINES];
   logic [67:0]       rd_data_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [20:0]       total_ff;
   logic              req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_acc && (count_ff < CNT_W'(MAX_LINES))) begin
         store_mem[count_ff[ADDR_W-1:0]] <= req_tdata[67:0];
      end
      if (state_ff == ST_RD) begin
         rd_data_ff <= store_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   // fields of the line just read
   logic signed [16:0] rd_lx, rd_ly, rd_lw, rd_lh;
   logic [15:0]        rd_w;
   logic signed [21:0] rem;
   logic [15:0]        vis;
   logic               line_stop;

   assign rd_lx = rd_data_ff[16:0];
   assign rd_ly = rd_data_ff[33:17];
   assign rd_lw = rd_data_ff[50:34];
   assign rd_lh = rd_data_ff[67:51];
   assign rd_w  = rd_lw[16] ? 16'd0 : rd_lw[15:0];

   // reveal width and walk registers
   logic [20:0] reveal_ff, accum_ff;
   logic [16:0] frac_clamp;
   logic [37:0] reveal_prod;

   assign frac_clamp  = (reveal_frac_ff > FRAC_ONE) ? FRAC_ONE : reveal_frac_ff;
   assign reveal_prod = {21'd0, frac_clamp} * {17'd0, total_ff};

   assign rem = $signed({1'b0, reveal_ff}) - $signed({1'b0, accum_ff});
   assign vis = (rem < $signed({6'd0, rd_w})) ? rem[15:0] : rd_w;
   assign line_stop = rem[21] || (rem == '0) || (rd_w == '0) ||
                      rd_lh[16] || (rd_lh == '0);

   // current line
   logic signed [16:0] ln_lx_ff;
   logic [15:0]        ln_w_ff, ln_vis_ff;
   logic signed [20:0] ln_sx_ff;

   // slice walk
   logic [15:0] wsoft_ff;
   logic [4:0]  steps_ff, k_ff;
   logic [15:0] sa_ff, sb_ff;
   logic        slice_ff;
   logic [4:0]  steps_max;
   logic [15:0] wsoft_in;
   logic [12:0] ceil16;
   logic [4:0]  steps_in;
   logic [15:0] part_w;

   assign steps_max = (soft_steps_ff > 5'(MAX_SOFT_SLICES)) ? 5'(MAX_SOFT_SLICES)
                                                             : soft_steps_ff;
   assign part_w    = ln_w_ff - ln_vis_ff;
   assign wsoft_in  = (soft_width_ff < part_w) ? soft_width_ff : part_w;
   assign ceil16    = 13'(({1'b0, wsoft_in} + 17'd15) >> 4);
   assign steps_in  = (ceil16 < {8'd0, steps_max}) ? ceil16[4:0] : steps_max;

   // strip under construction
   logic signed [21:0] st_sx_ff, st_sy_ff;
   logic [15:0]        st_sw_ff, st_sh_ff;
   logic signed [18:0] st_tx_ff, st_ty_ff;
   logic [7:0]         st_alpha_ff;
   logic [15:0]        st_uv_ff [4];
   logic [1:0]         tsel_ff;

   // texture coordinate operand
   logic signed [18:0] tpos;
   logic               tpos_pos;
   logic [12:0]        tsize;
   logic [15:0]        tq_sat;

   always_comb begin
      case (tsel_ff)
         2'd0:    tpos = st_tx_ff;
         2'd1:    tpos = st_ty_ff;
         2'd2:    tpos = st_tx_ff + $signed({3'd0, st_sw_ff});
         default: tpos = st_ty_ff + $signed({3'd0, st_sh_ff});
      endcase
   end
   assign tpos_pos = !tpos[18] && (tpos != '0);
   assign tsize    = tsel_ff[0] ? tex_height_ff : tex_width_ff;

   // shared divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   tlrs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign tq_sat = (div_rsp.quotient[DIV_W-1:16] != '0) ? 16'hFFFF
                                                         : div_rsp.quotient[15:0];

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = {8'd0, steps_ff};
      case (state_ff)
         ST_TEX: begin
            div_req.start    = tpos_pos;
            div_req.dividend = {tpos[17:0], 12'd0};
            div_req.divisor  = (tsize == '0) ? 13'd1 : tsize;
         end
         ST_SLB: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({4'd0, wsoft_ff} * {15'd0, k_ff + 5'd1});
         end
         ST_SLAL: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({5'd0, tint_alpha_ff} * {8'd0, steps_ff - k_ff});
         end
         default: ;
      endcase
   end

   // pending strip and output register
   logic         pend_valid_ff;
   logic [151:0] pend_data_ff;
   logic [151:0] cur_data;
   logic         rsp_valid_ff, rsp_last_ff;
   logic [151:0] rsp_data_ff;
   logic         out_free;
   logic         rsp_load;

   assign cur_data = {6'd0, st_alpha_ff, st_uv_ff[3], st_uv_ff[2], st_uv_ff[1], st_uv_ff[0],
                      st_sh_ff, st_sw_ff, st_sy_ff[20:0], st_sx_ff[20:0]};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = ((state_ff == ST_PUSH) || (state_ff == ST_FIN)) &&
                     pend_valid_ff && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // output register loads from the pending strip or drains
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (count_ff < CNT_W'(MAX_LINES)) begin
                     count_ff <= count_ff + 1'b1;
                     total_ff <= total_ff + (req_tdata[50] ? 21'd0
                                                           : {5'd0, req_tdata[49:34]});
                  end
                  if (req_tlast) begin
                     state_ff <= ST_REVEAL;
                  end
               end
            end
            ST_REVEAL: begin
               state_ff <= ST_RD;
            end
            ST_RD: begin
               state_ff <= (idx_ff == count_ff) ? ST_FIN : ST_LINE;
            end
            ST_LINE: begin
               state_ff <= line_stop ? ST_FIN : ST_TEX;
            end
            ST_TEX: begin
               if (tpos_pos) begin
                  state_ff <= ST_TEXW;
               end else if (tsel_ff == 2'd3) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_TEXW: begin
               if (div_rsp.done) begin
                  state_ff <= (tsel_ff == 2'd3) ? ST_PUSH : ST_TEX;
               end
            end
            ST_PUSH: begin
               if (!pend_valid_ff || out_free) begin
                  pend_valid_ff <= 1'b1;
                  if (slice_ff) begin
                     state_ff <= (k_ff + 5'd1 == steps_ff) ? ST_FIN : ST_SLB;
                  end else if (ln_vis_ff == ln_w_ff) begin
                     state_ff <= ST_RD;
                  end else if ((soft_width_ff != '0) && (steps_max != '0)) begin
                     state_ff <= ST_SLB;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_SLB: begin
               state_ff <= ST_SLBW;
            end
            ST_SLBW: begin
               if (div_rsp.done) begin
                  if (div_rsp.quotient[15:0] <= sa_ff) begin
                     state_ff <= (k_ff + 5'd1 == steps_ff) ? ST_FIN : ST_SLB;
                  end else begin
                     state_ff <= ST_SLAL;
                  end
               end
            end
            ST_SLAL: begin
               state_ff <= ST_SLALW;
            end
            ST_SLALW: begin
               if (div_rsp.done) begin
                  state_ff <= ST_TEX;
               end
            end
            ST_FIN: begin
               if (!pend_valid_ff) begin
                  count_ff <= '0;
                  total_ff <= '0;
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  pend_valid_ff <= 1'b0;
                  count_ff      <= '0;
                  total_ff      <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_REVEAL: begin
            reveal_ff <= reveal_prod[36:16];
            accum_ff  <= '0;
            idx_ff    <= '0;
         end
         ST_LINE: begin
            ln_lx_ff    <= rd_lx;
            ln_w_ff     <= rd_w;
            ln_vis_ff   <= vis;
            ln_sx_ff    <= 21'(text_x_ff) + 21'(rd_lx);
            st_sx_ff    <= 22'(text_x_ff) + 22'(rd_lx);
            st_sy_ff    <= 22'(text_y_ff) + 22'(rd_ly);
            st_sw_ff    <= vis;
            st_sh_ff    <= rd_lh[15:0];
            st_tx_ff    <= 19'(rd_lx);
            st_ty_ff    <= 19'(rd_ly);
            st_alpha_ff <= tint_alpha_ff;
            slice_ff    <= 1'b0;
            tsel_ff     <= 2'd0;
         end
         ST_TEX: begin
            if (!tpos_pos) begin
               st_uv_ff[tsel_ff] <= '0;
               tsel_ff           <= tsel_ff + 2'd1;
            end
         end
         ST_TEXW: begin
            if (div_rsp.done) begin
               st_uv_ff[tsel_ff] <= tq_sat;
               tsel_ff           <= tsel_ff + 2'd1;
            end
         end
         ST_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_data_ff <= pend_data_ff;
                  rsp_last_ff <= 1'b0;
               end
               pend_data_ff <= cur_data;
               if (slice_ff) begin
                  sa_ff <= sb_ff;
                  k_ff  <= k_ff + 5'd1;
               end else if (ln_vis_ff == ln_w_ff) begin
                  accum_ff <= accum_ff + {5'd0, ln_w_ff};
                  idx_ff   <= idx_ff + 1'b1;
               end else begin
                  wsoft_ff <= wsoft_in;
                  steps_ff <= (steps_in == '0) ? 5'd1 : steps_in;
                  k_ff     <= '0;
                  sa_ff    <= '0;
               end
            end
         end
         ST_SLBW: begin
            if (div_rsp.done) begin
               sb_ff <= div_rsp.quotient[15:0];
               if (div_rsp.quotient[15:0] <= sa_ff) begin
                  sa_ff <= div_rsp.quotient[15:0];
                  k_ff  <= k_ff + 5'd1;
               end
            end
         end
         ST_SLALW: begin
            if (div_rsp.done) begin
               st_alpha_ff <= div_rsp.quotient[7:0];
               st_sx_ff    <= 22'(ln_sx_ff) + {6'd0, ln_vis_ff} + {6'd0, sa_ff};
               st_sw_ff    <= sb_ff - sa_ff;
               st_tx_ff    <= 19'(ln_lx_ff) + {3'd0, ln_vis_ff} + {3'd0, sa_ff};
               slice_ff    <= 1'b1;
               tsel_ff     <= 2'd0;
            end
         end
         ST_FIN: begin
            if (pend_valid_ff && out_free) begin
               rsp_data_ff <= pend_data_ff;
               rsp_last_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // checks
   `TLRS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_LINES))
   `TLRS_ASSERT_NEXT(a_last_blocks, req_acc && req_tlast, !req_tready)
   `TLRS_ASSERT_NOW(a_idle_no_pend, state_ff == ST_IDLE, !pend_valid_ff)

endmodule
